// ----- src/ffp_pkg.sv -----
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and constants for the three point frame builder
// Holds the queued request record, status records and column codes.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] COL_X   = 2'd0;
  localparam logic [1:0] COL_Y   = 2'd1;
  localparam logic [1:0] COL_Z   = 2'd2;
  localparam logic [1:0] COL_ORG = 2'd3;

  localparam logic MODE_Z = 1'b1;

  localparam logic signed [17:0] UNIT_ONE = 18'sd65536;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][32:0] d1;
    logic [2:0][32:0] d2;
    logic             zmode;
  } job_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ----- src/ffp_in_if.sv -----
// ----------------------------------------------------------------------------
// ffp_in_if: request channel of the frame builder
// Carries the origin, the two further points and the mode bit.
// ----------------------------------------------------------------------------
interface ffp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic               operation;

  modport source(output valid, origin_x, origin_y, origin_z, first_x, first_y, first_z,
                 second_x, second_y, second_z, operation, input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, first_x, first_y, first_z,
               second_x, second_y, second_z, operation, output ready);
endinterface

// ----- src/ffp_out_if.sv -----
// ----------------------------------------------------------------------------
// ffp_out_if: result channel of the frame builder
// Carries one matrix column per transfer, four columns per request.
// ----------------------------------------------------------------------------
interface ffp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic               last;
  logic               degenerate;

  modport source(output valid, column, comp_x, comp_y, comp_z, last, degenerate,
                 input ready);
  modport sink(input valid, column, comp_x, comp_y, comp_z, last, degenerate,
               output ready);
endinterface

// ----- src/ffp_front.sv -----
// ----------------------------------------------------------------------------
// ffp_front: request intake
// Registers a request and forms the two direction vectors from the origin.
// ----------------------------------------------------------------------------
module ffp_front import ffp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  ffp_in_if.sink  in_ch,
  input  q_stat_t q_stat,
  output logic    q_push,
  output job_t    q_job
);

  logic v_r;
  job_t job_r;
  logic load;

  assign in_ch.ready = !v_r || !q_stat.full;
  assign load        = in_ch.valid && in_ch.ready;
  assign q_push      = v_r && !q_stat.full;
  assign q_job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      if (load) begin
        v_r             <= 1'b1;
        job_r.org[0]    <= in_ch.origin_x;
        job_r.org[1]    <= in_ch.origin_y;
        job_r.org[2]    <= in_ch.origin_z;
        job_r.d1[0]     <= {in_ch.first_x[31], in_ch.first_x} -
                           {in_ch.origin_x[31], in_ch.origin_x};
        job_r.d1[1]     <= {in_ch.first_y[31], in_ch.first_y} -
                           {in_ch.origin_y[31], in_ch.origin_y};
        job_r.d1[2]     <= {in_ch.first_z[31], in_ch.first_z} -
                           {in_ch.origin_z[31], in_ch.origin_z};
        job_r.d2[0]     <= {in_ch.second_x[31], in_ch.second_x} -
                           {in_ch.origin_x[31], in_ch.origin_x};
        job_r.d2[1]     <= {in_ch.second_y[31], in_ch.second_y} -
                           {in_ch.origin_y[31], in_ch.origin_y};
        job_r.d2[2]     <= {in_ch.second_z[31], in_ch.second_z} -
                           {in_ch.origin_z[31], in_ch.origin_z};
        job_r.zmode     <= in_ch.operation;
      end else if (q_push) begin
        v_r <= 1'b0;
      end
    end
  end

endmodule

// ----- src/ffp_queue.sv -----
// ----------------------------------------------------------------------------
// ffp_queue: request queue between intake and execution
// A small first-in first-out buffer of prepared requests.
// ----------------------------------------------------------------------------
module ffp_queue import ffp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    wr_job,
  input  logic    pop,
  output job_t    rd_job,
  output q_stat_t stat
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.valid = (cnt_r != '0);
  assign rd_job     = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= wr_job;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- src/ffp_norm.sv -----
// ----------------------------------------------------------------------------
// ffp_norm: shared vector normalization unit
// Scales a vector into range, takes its length by a bit-serial square root
// and divides each component by it with three serial dividers.
// ----------------------------------------------------------------------------
module ffp_norm import ffp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0][35:0] vec,
  output norm_stat_t       stat,
  output logic [2:0][17:0] unit
);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DINIT, N_DIV
  } nstate_t;

  nstate_t          state_r;
  logic [2:0][34:0] mag_r;
  logic [2:0]       neg_r;
  logic [4:0]       cnt_r;
  logic [59:0]      prod_r;
  logic [61:0]      acc_r;
  logic [61:0]      s_r;
  logic [62:0]      root_r;
  logic [62:0]      bit_r;
  logic [2:0][30:0] rem_r;
  logic [2:0][16:0] lo_r;
  logic [2:0][16:0] q_r;
  logic [2:0][17:0] unit_r;
  logic             done_r;
  logic             zero_r;

  logic [2:0][34:0] mag_in;
  logic [34:0]      m;
  logic [29:0]      sq_op;
  logic [63:0]      root_sum;
  logic [30:0]      len;
  logic [2:0][46:0] num;
  logic [2:0][31:0] trial;

  assign stat.done = done_r;
  assign stat.zero = zero_r;
  assign unit      = unit_r;
  assign len       = root_r[30:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec[i][35] ? 35'(-$signed(vec[i])) : vec[i][34:0];
      num[i]    = {1'b0, mag_r[i][29:0], 16'b0} + 47'(len[30:1]);
      trial[i]  = {rem_r[i], lo_r[i][16]};
    end
    m = mag_r[0];
    if (mag_r[1] > m) m = mag_r[1];
    if (mag_r[2] > m) m = mag_r[2];
    case (cnt_r[1:0])
      2'd0:    sq_op = mag_r[0][29:0];
      2'd1:    sq_op = mag_r[1][29:0];
      default: sq_op = mag_r[2][29:0];
    endcase
    root_sum = {1'b0, root_r} + {1'b0, bit_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          done_r <= start && (mag_in == '0);
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_in[i];
              neg_r[i] <= vec[i][35];
            end
            if (mag_in == '0) begin
              unit_r <= '0;
              zero_r <= 1'b1;
            end else begin
              zero_r  <= 1'b0;
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          cnt_r <= '0;
          acc_r <= '0;
          if (m[34]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 4;
          end else if (m[33:30] != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (m[29:25] == '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 4;
          end else if (!m[29]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          prod_r <= sq_op * sq_op;
          if (cnt_r != '0) acc_r <= acc_r + 62'(prod_r);
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd3) begin
            s_r     <= acc_r + 62'(prod_r);
            root_r  <= '0;
            bit_r   <= 63'd1 << 62;
            cnt_r   <= '0;
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          if ({2'b0, s_r} >= root_sum) begin
            s_r    <= 62'({2'b0, s_r} - root_sum);
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) state_r <= N_DINIT;
        end
        N_DINIT: begin
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= {1'b0, num[i][46:17]};
            lo_r[i]  <= num[i][16:0];
          end
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (trial[i] >= {1'b0, len}) begin
              rem_r[i] <= 31'(trial[i] - {1'b0, len});
              q_r[i]   <= {q_r[i][15:0], 1'b1};
            end else begin
              rem_r[i] <= trial[i][30:0];
              q_r[i]   <= {q_r[i][15:0], 1'b0};
            end
            lo_r[i] <= lo_r[i] << 1;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd17) begin
            for (int i = 0; i < 3; i++) begin
              unit_r[i] <= neg_r[i] ? 18'(-$signed({1'b0, q_r[i]})) : {1'b0, q_r[i]};
            end
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ffp_back.sv -----
// ----------------------------------------------------------------------------
// ffp_back: frame execution sequencer
// Runs four normalizations and two cross products per request and emits
// the four matrix columns through a registered output stage.
// ----------------------------------------------------------------------------
module ffp_back import ffp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             norm_start,
  output logic [2:0][35:0] norm_vec,
  input  norm_stat_t       norm_stat,
  input  logic [2:0][17:0] norm_unit,
  ffp_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    B_IDLE, B_N1, B_N2, B_X1, B_N3, B_X2, B_N4, B_EMIT
  } bstate_t;

  bstate_t          state_r;
  job_t             job_r;
  logic             issued_r;
  logic             bad_r;
  logic [2:0][17:0] ax_r;
  logic [2:0][17:0] ay_r;
  logic [2:0][17:0] az_r;
  logic [2:0][17:0] dn_r;
  logic [2:0][35:0] tmp_r;
  logic [35:0]      acc_r;
  logic [35:0]      prod_r;
  logic [2:0]       step_r;
  logic [1:0]       col_r;
  logic             out_v_r;
  logic [1:0]       out_col_r;
  logic [31:0]      out_x_r;
  logic [31:0]      out_y_r;
  logic [31:0]      out_z_r;
  logic             out_last_r;
  logic             out_bad_r;

  logic             in_norm;
  logic [2:0][17:0] opa;
  logic [2:0][17:0] opb;
  logic [17:0]      fa;
  logic [17:0]      fb;
  logic [2:0]       cstep;
  logic [2:0][17:0] colv;
  logic             out_free;

  assign out_ch.valid      = out_v_r;
  assign out_ch.column     = out_col_r;
  assign out_ch.comp_x     = out_x_r;
  assign out_ch.comp_y     = out_y_r;
  assign out_ch.comp_z     = out_z_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.degenerate = out_bad_r;
  assign out_free          = !out_v_r || out_ch.ready;

  assign q_pop      = (state_r == B_IDLE) && q_stat.valid;
  assign in_norm    = (state_r == B_N1) || (state_r == B_N2) ||
                      (state_r == B_N3) || (state_r == B_N4);
  assign norm_start = in_norm && !issued_r;
  assign cstep      = step_r - 1'b1;

  always_comb begin
    unique case (state_r)
      B_N1:    for (int i = 0; i < 3; i++) norm_vec[i] = 36'($signed(job_r.d1[i]));
      B_N2:    for (int i = 0; i < 3; i++) norm_vec[i] = 36'($signed(job_r.d2[i]));
      default: norm_vec = tmp_r;
    endcase
    if (state_r == B_X1) begin
      opa = (job_r.zmode == MODE_Z) ? dn_r : ax_r;
      opb = (job_r.zmode == MODE_Z) ? ax_r : dn_r;
    end else begin
      opa = (job_r.zmode == MODE_Z) ? ax_r : az_r;
      opb = (job_r.zmode == MODE_Z) ? ay_r : ax_r;
    end
    case (step_r)
      3'd0:    begin fa = opa[1]; fb = opb[2]; end
      3'd1:    begin fa = opa[2]; fb = opb[1]; end
      3'd2:    begin fa = opa[2]; fb = opb[0]; end
      3'd3:    begin fa = opa[0]; fb = opb[2]; end
      3'd4:    begin fa = opa[0]; fb = opb[1]; end
      default: begin fa = opa[1]; fb = opb[0]; end
    endcase
    case (col_r)
      COL_X:   colv = ax_r;
      COL_Y:   colv = ay_r;
      default: colv = az_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      issued_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if ((state_r == B_EMIT) && out_free) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      if (norm_start) issued_r <= 1'b1;
      unique case (state_r)
        B_IDLE: begin
          if (q_stat.valid) begin
            job_r   <= q_job;
            bad_r   <= 1'b0;
            state_r <= B_N1;
          end
        end
        B_N1, B_N2, B_N3, B_N4: begin
          if (issued_r && norm_stat.done) begin
            issued_r <= 1'b0;
            bad_r    <= bad_r | norm_stat.zero;
            step_r   <= '0;
            unique case (state_r)
              B_N1: begin
                ax_r    <= norm_unit;
                state_r <= B_N2;
              end
              B_N2: begin
                dn_r    <= norm_unit;
                state_r <= B_X1;
              end
              B_N3: begin
                if (job_r.zmode == MODE_Z) ay_r <= norm_unit;
                else az_r <= norm_unit;
                state_r <= B_X2;
              end
              default: begin
                if (job_r.zmode == MODE_Z) az_r <= norm_unit;
                else ay_r <= norm_unit;
                col_r   <= COL_X;
                state_r <= B_EMIT;
              end
            endcase
          end
        end
        B_X1, B_X2: begin
          prod_r <= $signed(fa) * $signed(fb);
          step_r <= step_r + 1'b1;
          if (step_r != '0) begin
            if (!cstep[0]) acc_r <= prod_r;
            else tmp_r[cstep[2:1]] <= acc_r - prod_r;
          end
          if (step_r == 3'd6) begin
            state_r <= (state_r == B_X1) ? B_N3 : B_N4;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_col_r  <= col_r;
            out_last_r <= (col_r == COL_ORG);
            out_bad_r  <= bad_r;
            if (col_r == COL_ORG) begin
              out_x_r <= job_r.org[0];
              out_y_r <= job_r.org[1];
              out_z_r <= job_r.org[2];
              state_r <= B_IDLE;
            end else begin
              out_x_r <= 32'($signed(colv[0]));
              out_y_r <= 32'($signed(colv[1]));
              out_z_r <= 32'($signed(colv[2]));
            end
            col_r <= col_r + 1'b1;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/frame_from_three_points_top.sv -----
// Run time is set by the shared normalization unit, which runs four times per
// request (bit-serial square root, serial division and range scaling each pass).
// Flow: requests execute one at a time; intake and a two entry queue take up to
// three requests ahead, and columns leave one per cycle while out_ch.ready allows.
// Reset: synchronous, active low; clears all control state, no clearing pass.
// ----------------------------------------------------------------------------
// frame_from_three_points_top: orthonormal frame from three points
// Builds the x, y and z axes of a frame and emits them with the origin as
// four columns of a homogeneous matrix.
// ----------------------------------------------------------------------------
module frame_from_three_points_top import ffp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ffp_in_if.sink    in_ch,
  ffp_out_if.source out_ch
);

  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  job_t             q_wr_job;
  job_t             q_rd_job;
  logic             norm_start;
  logic [2:0][35:0] norm_vec;
  norm_stat_t       norm_stat;
  logic [2:0][17:0] norm_unit;

  ffp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_job  (q_wr_job)
  );

  ffp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .pop    (q_pop),
    .rd_job (q_rd_job),
    .stat   (q_stat)
  );

  ffp_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec   (norm_vec),
    .stat  (norm_stat),
    .unit  (norm_unit)
  );

  ffp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_job      (q_rd_job),
    .q_pop      (q_pop),
    .norm_start (norm_start),
    .norm_vec   (norm_vec),
    .norm_stat  (norm_stat),
    .norm_unit  (norm_unit),
    .out_ch     (out_ch)
  );

  a_last_is_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == (out_ch.column == COL_ORG)))
    else $error("last flag does not match the origin column");

  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    norm_stat.done && norm_stat.zero |-> norm_unit == '0)
    else $error("zero-length vector did not give a zero unit vector");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    norm_stat.done |->
      ($signed(norm_unit[0]) <= UNIT_ONE) && ($signed(norm_unit[0]) >= -UNIT_ONE) &&
      ($signed(norm_unit[1]) <= UNIT_ONE) && ($signed(norm_unit[1]) >= -UNIT_ONE) &&
      ($signed(norm_unit[2]) <= UNIT_ONE) && ($signed(norm_unit[2]) >= -UNIT_ONE))
    else $error("normalized component out of unit range");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("queue popped while empty");

endmodule
